/* rtl/gru_pkg.sv */
// Shared types and constants for the Givens rotation unit.
// No dependencies.
package gru_pkg;

  localparam logic OP_GEN   = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [31:0] Q16_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

  // Fields of one item as it moves through the pipeline.
  typedef struct packed {
    logic        op;
    logic        zero;
    logic        y_larger;
    logic        x_neg;
    logic        y_neg;
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] rsq;
  } gen_ctl_t;

endpackage

/* rtl/gru_divsqrt.sv */
// Pipelined restoring divider: two quotient bits per stage, 64-bit dividend,
// 64-bit divisor, rounded quotient. Depends on nothing.
module gru_divsqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo
);

  // Stage k holds remainder and quotient bits produced so far.
  logic [64:0] rem_r [0:32];
  logic [63:0] q_r   [0:32];
  logic [63:0] n_r   [0:32];
  logic [64:0] d_r   [0:32];

  // Quotient of (2n + d) / (2d); two quotient bits per stage for 32 stages.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      n_r[0]   <= num + num + den;
      d_r[0]   <= {den, 1'b0};
      q_r[0]   <= '0;
      for (int k = 0; k < 32; k++) begin
        logic [65:0] r1;
        logic [65:0] r2;
        logic        b1;
        logic        b2;
        r1 = {rem_r[k], n_r[k][63]};
        b1 = r1 >= {1'b0, d_r[k]};
        if (b1) r1 = r1 - {1'b0, d_r[k]};
        r2 = {r1[64:0], n_r[k][62]};
        b2 = r2 >= {1'b0, d_r[k]};
        if (b2) r2 = r2 - {1'b0, d_r[k]};
        rem_r[k+1] <= r2[64:0];
        n_r[k+1]   <= {n_r[k][61:0], 2'b00};
        d_r[k+1]   <= d_r[k];
        q_r[k+1]   <= {q_r[k][61:0], b1, b2};
      end
    end
  end

  assign quo = q_r[32];

endmodule

/* rtl/gru_sqrt.sv */
// Pipelined rounded integer square root of a 64-bit value, one result bit
// per stage. Depends on nothing.
module gru_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] val,
  output logic [31:0] root
);

  logic [65:0] rem_r [0:32];
  logic [31:0] res_r [0:32];
  logic [63:0] v_r   [0:32];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      res_r[0] <= '0;
      v_r[0]   <= val;
      for (int k = 0; k < 32; k++) begin
        logic [65:0] r;
        logic [65:0] trial;
        r     = {rem_r[k][63:0], v_r[k][63:62]};
        trial = {32'd0, res_r[k], 2'b01};
        if (r >= trial) begin
          rem_r[k+1] <= r - trial;
          res_r[k+1] <= {res_r[k][30:0], 1'b1};
        end else begin
          rem_r[k+1] <= r;
          res_r[k+1] <= {res_r[k][30:0], 1'b0};
        end
        v_r[k+1] <= {v_r[k][61:0], 2'b00};
      end
    end
  end

  // Round: remainder above root means value past (root+0.5)^2.
  assign root = res_r[32] +
                32'(rem_r[32] > {34'd0, res_r[32]});

endmodule

/* rtl/givens_rotation_unit.sv */
// Givens rotation unit: stream top level with deep pipeline of dividers,
// square roots and multipliers. Depends on gru_pkg, gru_divsqrt, gru_sqrt.
//
// A new pair is taken every cycle unless the output stalls; each result
// passes through the chain of ratio divider, square root of 1 + t^2 and
// reciprocal divider, each a 33-stage unit, plus six single-register
// stages; the magnitude root runs beside the ratio divider.
// Apply items travel the same pipeline so order is kept. The whole pipeline
// advances only when its last stage is free, so a stall loses nothing.
module givens_rotation_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // cos_in, sin_in, x_in, y_in
  input  logic         in_tuser,  // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata  // cos_out, sin_out, first_out, second_out
);

  localparam int LAT = 3 * 33 + 6;

  logic en;
  logic [LAT-1:0] vld_r;
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  // Stage 0: unpack, magnitudes, apply products.
  logic signed [31:0] ci, si, xi, yi;
  assign ci = in_tdata[31:0];
  assign si = in_tdata[63:32];
  assign xi = in_tdata[95:64];
  assign yi = in_tdata[127:96];
  logic [31:0] ax, ay;
  assign ax = xi[31] ? 32'(-xi) : 32'(xi);
  assign ay = yi[31] ? 32'(-yi) : 32'(yi);

  gru_pkg::gen_ctl_t c0_r;
  logic signed [63:0] p_cx_r, p_sy_r, p_cy_r, p_sx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r.op       <= in_tuser;
      c0_r.zero     <= (ax == 0) && (ay == 0);
      c0_r.y_larger <= ay > ax;
      c0_r.x_neg    <= xi[31];
      c0_r.y_neg    <= yi[31];
      c0_r.a        <= (ay > ax) ? ay : ax;
      c0_r.b        <= (ay > ax) ? ax : ay;
      c0_r.rsq      <= 64'(ax) * 64'(ax);
      p_cx_r <= ci * xi;
      p_sy_r <= si * yi;
      p_cy_r <= ci * yi;
      p_sx_r <= si * xi;
    end
  end

  // Stage 1: r^2 completion and apply sums.
  gru_pkg::gen_ctl_t c1_r;
  logic [63:0] ay2_r;
  logic signed [65:0] s1_r, s2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ay2_r <= 64'(c0_r.y_larger ? c0_r.a : c0_r.b) * 64'(c0_r.y_larger ? c0_r.a : c0_r.b);
      c1_r  <= c0_r;
      s1_r  <= 66'(p_cx_r) + 66'(p_sy_r);
      s2_r  <= 66'(p_cy_r) - 66'(p_sx_r);
    end
  end
  logic [63:0] rsq;
  assign rsq = c1_r.rsq + ay2_r;

  // Stage 2: saturate apply results.
  function automatic logic [31:0] sat_q16(input logic signed [65:0] s);
    logic [65:0] m;
    logic [35:0] q;
    m = s[65] ? 66'(-s) : 66'(s);
    q = 36'((m + 66'(1 << 29)) >> 30);
    if (s[65]) sat_q16 = (q >= 36'h8000_0000) ? gru_pkg::Q16_MIN : 32'(-q);
    else sat_q16 = (q > 36'h7fff_ffff) ? gru_pkg::Q16_MAX : q[31:0];
  endfunction

  gru_pkg::gen_ctl_t c2_r;
  logic [63:0] rsq2_r;
  logic [31:0] ap1_r, ap2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      c2_r   <= c1_r;
      rsq2_r <= rsq;
      ap1_r  <= sat_q16(s1_r);
      ap2_r  <= sat_q16(s2_r);
    end
  end

  // Ratio t = round(b*2^30 / a); a zero divisor is replaced (zero pair only).
  logic [63:0] t_q;
  gru_divsqrt u_tdiv (.clk(clk), .en(en),
    .num({2'b00, c2_r.b, 30'd0}),
    .den(c2_r.zero ? 64'd1 : 64'(c2_r.a)), .quo(t_q));
  logic [31:0] r_root;
  gru_sqrt u_rsqrt (.clk(clk), .en(en), .val(rsq2_r), .root(r_root));

  // Delay lines for side data across the pipelined divider and root units.
  localparam int D1 = 33;
  gru_pkg::gen_ctl_t cd_r [0:3*D1+1];
  logic [31:0] a1_r [0:3*D1+1];
  logic [31:0] a2_r [0:3*D1+1];
  logic [31:0] rr_r [0:2*D1+1];
  logic [31:0] t_r  [0:2*D1];
  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0] <= c2_r;
      a1_r[0] <= ap1_r;
      a2_r[0] <= ap2_r;
      for (int k = 1; k <= 3*D1+1; k++) begin
        cd_r[k] <= cd_r[k-1];
        a1_r[k] <= a1_r[k-1];
        a2_r[k] <= a2_r[k-1];
      end
      rr_r[0] <= r_root;
      for (int k = 1; k <= 2*D1+1; k++) rr_r[k] <= rr_r[k-1];
      t_r[0] <= t_q[31:0];
      for (int k = 1; k <= 2*D1; k++) t_r[k] <= t_r[k-1];
    end
  end

  // d = round(sqrt(2^60 + t^2)).
  logic [63:0] tt_r;
  always_ff @(posedge clk) begin
    if (en) tt_r <= 64'(t_q[31:0]) * 64'(t_q[31:0]) + (64'd1 << 60);
  end
  logic [31:0] d_root;
  gru_sqrt u_dsqrt (.clk(clk), .en(en), .val(tt_r), .root(d_root));

  // big = round(2^60 / d).
  logic [63:0] big_q;
  gru_divsqrt u_bdiv (.clk(clk), .en(en), .num(64'd1 << 60),
    .den(64'(d_root)), .quo(big_q));

  // sml = round(t * big / 2^30), then signs and output mux.
  logic [63:0] tb_r;
  logic [31:0] big_r;
  always_ff @(posedge clk) begin
    if (en) begin
      tb_r  <= 64'(t_r[2*D1]) * 64'(big_q[31:0]);
      big_r <= big_q[31:0];
    end
  end
  logic [31:0] sml;
  assign sml = 32'((tb_r + (64'd1 << 29)) >> 30);

  gru_pkg::gen_ctl_t cf;
  assign cf = cd_r[3*D1+1];
  logic [31:0] cm, sm, cv, sv, rv;
  assign cm = cf.y_larger ? sml : big_r;
  assign sm = cf.y_larger ? big_r : sml;
  assign cv = cf.x_neg ? 32'(-cm) : cm;
  assign sv = cf.y_neg ? 32'(-sm) : sm;
  assign rv = rr_r[2*D1+1][31] ? gru_pkg::Q16_MAX : rr_r[2*D1+1];

  logic [127:0] res_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (cf.op == gru_pkg::OP_APPLY)
        res_r <= {a2_r[3*D1+1], a1_r[3*D1+1], 64'd0};
      else if (cf.zero)
        res_r <= {64'd0, 32'd0, gru_pkg::ONE_Q30};
      else
        res_r <= {32'd0, rv, sv, cv};
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = res_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline stalled while empty at tail");

endmodule

/* tb/givens_rotation_scoreboard.sv */
`timescale 1ns / 100ps
// Watches both stream channels of givens_rotation_unit, predicts each result
// from the accepted pair and compares field by field. Depends on gru_pkg.
module givens_rotation_scoreboard (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  output int           fail_count,
  output int           pending
);

  logic [127:0] rotation_q[$];

  function automatic longint unsigned sqrt_nearest(longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    if (v > res) res = res + 1;
    return res;
  endfunction

  function automatic logic [31:0] q30_sum_to_q16(logic signed [95:0] p1,
                                                 logic signed [95:0] p2);
    logic signed [95:0] s;
    logic [95:0] m;
    logic [95:0] q;
    s = p1 + p2;
    m = (s < 0) ? -s : s;
    q = (m + 96'd536870912) >> 30;
    if (s < 0) return (q >= 96'h8000_0000) ? gru_pkg::Q16_MIN : 32'(-q);
    return (q > 96'h7fff_ffff) ? gru_pkg::Q16_MAX : q[31:0];
  endfunction

  function automatic logic [127:0] rotate_or_generate(logic op, logic [127:0] d);
    logic signed [31:0] c, s, x, y;
    longint unsigned ax, ay, a, b, t, dd, big, sml, r, cm, sm;
    logic y_larger;
    logic [31:0] cv, sv;
    c = d[31:0];
    s = d[63:32];
    x = d[95:64];
    y = d[127:96];
    if (op == gru_pkg::OP_APPLY) begin
      return {q30_sum_to_q16(96'(c) * 96'(y), -(96'(s) * 96'(x))),
              q30_sum_to_q16(96'(c) * 96'(x), 96'(s) * 96'(y)),
              32'd0, 32'd0};
    end
    ax = (x < 0) ? 64'(-65'(x)) : 64'(x);
    ay = (y < 0) ? 64'(-65'(y)) : 64'(y);
    if (ax == 0 && ay == 0) return {32'd0, 32'd0, 32'd0, gru_pkg::ONE_Q30};
    y_larger = ay > ax;
    a = y_larger ? ay : ax;
    b = y_larger ? ax : ay;
    t = (2 * (b << 30) + a) / (2 * a);
    dd = sqrt_nearest((64'd1 << 60) + t * t);
    big = (2 * (64'd1 << 60) + dd) / (2 * dd);
    sml = (t * big + (64'd1 << 29)) >> 30;
    cm = y_larger ? sml : big;
    sm = y_larger ? big : sml;
    cv = (x < 0) ? -cm[31:0] : cm[31:0];
    sv = (y < 0) ? -sm[31:0] : sm[31:0];
    r = sqrt_nearest(ax * ax + ay * ay);
    if (r > 64'h7fff_ffff) r = 64'h7fff_ffff;
    return {32'd0, r[31:0], sv, cv};
  endfunction

  initial fail_count = 0;
  assign pending = rotation_q.size();

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) rotation_q.push_back(rotate_or_generate(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (rotation_q.size() == 0) begin
          $error("unexpected result transfer %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = rotation_q.pop_front();
          if (want != out_tdata) begin
            if (want[31:0] != out_tdata[31:0])
              $error("cos_out expected %h actual %h", want[31:0], out_tdata[31:0]);
            if (want[63:32] != out_tdata[63:32])
              $error("sin_out expected %h actual %h", want[63:32], out_tdata[63:32]);
            if (want[95:64] != out_tdata[95:64])
              $error("first_out expected %h actual %h", want[95:64], out_tdata[95:64]);
            if (want[127:96] != out_tdata[127:96])
              $error("second_out expected %h actual %h", want[127:96], out_tdata[127:96]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/givens_rotation_unit_test.sv */
`timescale 1ns / 100ps
// Stimulus and verdict for givens_rotation_unit: directed and random pairs with
// random idling on both channels. Depends on gru_pkg, givens_rotation_scoreboard.
module givens_rotation_unit_test;

  localparam int NUM_RANDOM = 750;
  localparam int WATCHDOG_LIMIT = 5000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tuser = gru_pkg::OP_GEN;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  int           gen_count = 0;
  int           apply_count = 0;
  logic         calm_phase = 1'b0;

  always #1 clk = ~clk;

  givens_rotation_unit dut (.*);
  givens_rotation_scoreboard scoreboard (.*);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("FAIL givens_rotation_unit");
      $finish;
    end
  end

  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm_phase ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_pair(logic op, logic [31:0] c, logic [31:0] s,
                           logic [31:0] x, logic [31:0] y);
    int gap;
    gap = calm_phase ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {y, x, s, c};
    do @(posedge clk); while (!in_tready);
    if (op == gru_pkg::OP_APPLY) apply_count++;
    else gen_count++;
  endtask

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return 32'($signed(32'($urandom_range(0, 2000))) - 1000);
      2: return 32'($signed(32'($urandom_range(0, 32'h0100_0000))) - 32'sh0080_0000);
      3: return $urandom_range(0, 7) == 0 ? 32'd0 : 32'($urandom_range(0, 65536)) << 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_q30();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed(32'($urandom_range(0, 32'h8000_0000))) - 32'sh4000_0000);
  endfunction

  initial begin
    logic op;
    logic [31:0] x;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair(gru_pkg::OP_GEN, $urandom, $urandom, 32'd0, 32'd0);
    send_pair(gru_pkg::OP_GEN, 32'd0, 32'd0, 32'h7fff_ffff, 32'd0);
    send_pair(gru_pkg::OP_GEN, 32'd0, 32'd0, 32'd0, 32'h8000_0000);
    send_pair(gru_pkg::OP_GEN, 32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000);
    send_pair(gru_pkg::OP_GEN, 32'd0, 32'd0, 32'h7fff_ffff, 32'h7fff_ffff);
    send_pair(gru_pkg::OP_GEN, 32'd0, 32'd0, 32'h0003_0000, 32'hfffc_0000);
    send_pair(gru_pkg::OP_GEN, 32'd0, 32'd0, 32'hfffd_0000, 32'h0004_0000);
    send_pair(gru_pkg::OP_GEN, 32'd0, 32'd0, 32'hffff_fff0, 32'h0000_0010);
    send_pair(gru_pkg::OP_GEN, 32'd0, 32'd0, 32'd1, 32'h7fff_ffff);
    send_pair(gru_pkg::OP_GEN, 32'd0, 32'd0, 32'hffff_ffff, 32'd0);
    send_pair(gru_pkg::OP_APPLY, gru_pkg::ONE_Q30, 32'd0, 32'h1234_5678, 32'h8765_4321);
    send_pair(gru_pkg::OP_APPLY, 32'd0, gru_pkg::ONE_Q30, 32'h1234_5678, 32'h8765_4321);
    send_pair(gru_pkg::OP_APPLY, 32'hc000_0000, 32'hc000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_pair(gru_pkg::OP_APPLY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pair(gru_pkg::OP_APPLY, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_pair(gru_pkg::OP_APPLY, 32'h2d41_3ccd, 32'hd2be_c333, 32'h0001_8000, 32'hfffe_8000);
    send_pair(gru_pkg::OP_APPLY, gru_pkg::ONE_Q30, gru_pkg::ONE_Q30, 32'd0, 32'd0);
    send_pair(gru_pkg::OP_APPLY, 32'h0000_0001, 32'hffff_ffff, 32'h0000_8000, 32'h0000_7fff);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 64 == 0) calm_phase = ($urandom_range(0, 3) == 0);
      op = 1'($urandom_range(0, 1));
      x = pick_q16();
      send_pair(op, pick_q30(), pick_q30(), x,
                $urandom_range(0, 5) == 0 ? x : pick_q16());
    end
    calm_phase = 1'b0;
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d generate and %0d apply transfers under random idling",
             gen_count, apply_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS givens_rotation_unit");
    end else begin
      $display("FAIL givens_rotation_unit");
    end
    $finish;
  end

endmodule

/* givens_rotation_unit.f */
rtl/gru_pkg.sv
rtl/gru_divsqrt.sv
rtl/gru_sqrt.sv
rtl/givens_rotation_unit.sv
tb/givens_rotation_scoreboard.sv
tb/givens_rotation_unit_test.sv
